@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files of this project.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ src/kdp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdp_pkg
// Shared types and constants of the k-transaction profit block.
// ----------------------------------------------------------------------------
package kdp_pkg;

  localparam int PRICE_W  = 16;
  localparam int HOLD_W   = 34;
  localparam int CLOSED_W = 32;
  localparam int PROFIT_W = 32;

  // Holding value before any buy: far below anything a sale can lift.
  localparam logic signed [HOLD_W-1:0] HOLD_NEG_INF = {2'b10, {(HOLD_W-2){1'b0}}};
  localparam logic [CLOSED_W-1:0] SAT_MAX = {CLOSED_W{1'b1}};

  // Word index of each configuration register (byte address bit 2).
  localparam logic REG_MAX_TRANSACTIONS = 1'b0;
  localparam logic REG_UNLIMITED_MODE   = 1'b1;

  localparam logic [4:0] MAX_TRANSACTIONS_RST = 5'd2;

  typedef struct packed {
    logic en;   // a price word is taken this cycle
    logic clr;  // the word starts a new series
  } cell_ctrl_t;

endpackage

@@ src/kdp_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdp_cell
// One transaction-count cell: best holding and best closed value.
// ----------------------------------------------------------------------------
module kdp_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  kdp_pkg::cell_ctrl_t             ctrl,
  input  logic [kdp_pkg::PRICE_W-1:0]     price,
  input  logic [kdp_pkg::CLOSED_W-1:0]    left_closed,
  output logic [kdp_pkg::CLOSED_W-1:0]    closed_eff,
  output logic [kdp_pkg::CLOSED_W-1:0]    closed_nxt
);

  logic signed [kdp_pkg::HOLD_W-1:0] hold_r;
  logic signed [kdp_pkg::HOLD_W-1:0] hold_nxt;
  logic signed [kdp_pkg::HOLD_W-1:0] hold_eff;
  logic        [kdp_pkg::CLOSED_W-1:0] closed_r;
  logic signed [kdp_pkg::HOLD_W:0]   sold;
  logic signed [kdp_pkg::HOLD_W:0]   bought;
  logic signed [kdp_pkg::HOLD_W:0]   price_s;

  // A new series sees the reset values instead of the stored ones.
  assign hold_eff   = ctrl.clr ? kdp_pkg::HOLD_NEG_INF : hold_r;
  assign closed_eff = ctrl.clr ? '0 : closed_r;

  assign price_s = $signed({{(kdp_pkg::HOLD_W + 1 - kdp_pkg::PRICE_W){1'b0}}, price});
  assign sold    = $signed({hold_eff[kdp_pkg::HOLD_W-1], hold_eff}) + price_s;
  assign bought  = $signed({{(kdp_pkg::HOLD_W + 1 - kdp_pkg::CLOSED_W){1'b0}}, left_closed})
                   - price_s;

  always_comb begin
    priority if (sold > $signed({3'b000, kdp_pkg::SAT_MAX})) begin
      closed_nxt = kdp_pkg::SAT_MAX;
    end else if (sold > $signed({3'b000, closed_eff})) begin
      closed_nxt = sold[kdp_pkg::CLOSED_W-1:0];
    end else begin
      closed_nxt = closed_eff;
    end
    if (bought > $signed({hold_eff[kdp_pkg::HOLD_W-1], hold_eff})) begin
      hold_nxt = bought[kdp_pkg::HOLD_W-1:0];
    end else begin
      hold_nxt = hold_eff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= kdp_pkg::HOLD_NEG_INF;
      closed_r <= '0;
    end else if (ctrl.en) begin
      hold_r   <= hold_nxt;
      closed_r <= closed_nxt;
    end
  end

endmodule

@@ src/kdp_upsum.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdp_upsum
// Running, saturating sum of every upward step between consecutive prices.
// ----------------------------------------------------------------------------
module kdp_upsum (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kdp_pkg::cell_ctrl_t           ctrl,
  input  logic [kdp_pkg::PRICE_W-1:0]   price,
  output logic [kdp_pkg::PROFIT_W-1:0]  total_nxt
);

  logic [kdp_pkg::PRICE_W-1:0]  prev_r;
  logic                         have_r;
  logic [kdp_pkg::PROFIT_W-1:0] total_r;
  logic                         have_eff;
  logic [kdp_pkg::PRICE_W-1:0]  prev_eff;
  logic [kdp_pkg::PROFIT_W-1:0] total_eff;
  logic [kdp_pkg::PROFIT_W:0]   sum;

  assign have_eff  = ctrl.clr ? 1'b0 : have_r;
  assign prev_eff  = ctrl.clr ? '0 : prev_r;
  assign total_eff = ctrl.clr ? '0 : total_r;

  assign sum = {1'b0, total_eff}
             + (kdp_pkg::PROFIT_W + 1)'(price - prev_eff);

  always_comb begin
    priority if (!have_eff || price <= prev_eff) begin
      total_nxt = total_eff;
    end else if (sum[kdp_pkg::PROFIT_W]) begin
      total_nxt = kdp_pkg::SAT_MAX;
    end else begin
      total_nxt = sum[kdp_pkg::PROFIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      have_r  <= 1'b0;
      total_r <= '0;
    end else if (ctrl.en) begin
      prev_r  <= price;
      have_r  <= 1'b1;
      total_r <= total_nxt;
    end
  end

endmodule

@@ src/k_transaction_max_profit_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// k_transaction_max_profit_dp
// Best stock profit with at most k buy-sell transactions over a price stream.
// ----------------------------------------------------------------------------
// Each input word carries one price and a flag that starts a new series; each
// word yields exactly one result word with the best profit so far. The work is
// done by a row of MAX_CELLS cells, cell j keeping the best holding value and
// the best closed value for j+1 transactions. All cells update in the same
// cycle from their own registers and the closed value of their left neighbor,
// so the block takes one word per clock cycle unless stalled, and the result
// is registered in the cycle after the word is taken. The cell row is the only
// loop, and since every cell needs just two adds, three compares and selects,
// no cell iterates. The output register is a one-word buffer: a new word is
// taken whenever it is empty or is being drained in the same cycle, so a
// stalled result side stalls the input side without losing a word. In limited
// mode the result is the closed value of cell k-1 (k saturated to MAX_CELLS,
// zero for k equal to zero); in unlimited mode it is the saturating sum of all
// upward price steps, which is tracked on every word regardless of mode.
// Configuration writes are meant to happen while the block is idle.
// ----------------------------------------------------------------------------
module k_transaction_max_profit_dp #(
  parameter int MAX_CELLS  = 16,
  parameter int PRICE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] price
  input  logic        in_tuser,   // [0] series_start
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] best_profit
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int PB = (PRICE_BITS < kdp_pkg::PRICE_W) ? PRICE_BITS : kdp_pkg::PRICE_W;
  localparam logic [kdp_pkg::PRICE_W-1:0] PRICE_MASK =
    kdp_pkg::PRICE_W'((17'd1 << PB) - 17'd1);
  localparam int SEL_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam logic [6:0] CELLS_K = 7'(MAX_CELLS);

  // Configuration registers.
  logic [4:0] max_tx_r;
  logic       unlim_r;
  logic       cfg_wr;

  // Datapath control and buses.
  kdp_pkg::cell_ctrl_t              ctrl;
  logic                             accept;
  logic [kdp_pkg::PRICE_W-1:0]      price_m;
  logic [kdp_pkg::CLOSED_W-1:0]     chain   [MAX_CELLS+1];
  logic [kdp_pkg::CLOSED_W-1:0]     closed_nxt [MAX_CELLS];
  logic [kdp_pkg::PROFIT_W-1:0]     up_total_nxt;
  logic [6:0]                       k_sat;
  logic [SEL_W-1:0]                 sel;
  logic [kdp_pkg::PROFIT_W-1:0]     profit;

  // Result buffer.
  logic                             out_valid_r;
  logic [kdp_pkg::PROFIT_W-1:0]     out_data_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tx_r <= kdp_pkg::MAX_TRANSACTIONS_RST;
      unlim_r  <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        kdp_pkg::REG_MAX_TRANSACTIONS: max_tx_r <= cfg_pwdata[4:0];
        kdp_pkg::REG_UNLIMITED_MODE:   unlim_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      kdp_pkg::REG_MAX_TRANSACTIONS: cfg_prdata = {27'd0, max_tx_r};
      kdp_pkg::REG_UNLIMITED_MODE:   cfg_prdata = {31'd0, unlim_r};
      default:                       cfg_prdata = '0;
    endcase
  end

  // A word is taken whenever the result buffer is empty or drains now.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign ctrl.en   = accept;
  assign ctrl.clr  = in_tuser;
  assign price_m   = in_tdata[kdp_pkg::PRICE_W-1:0] & PRICE_MASK;

  // The row of cells; the zero-transaction closed value is always zero.
  assign chain[0] = '0;

  for (genvar j = 0; j < MAX_CELLS; j++) begin : g_cell
    kdp_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .price       (price_m),
      .left_closed (chain[j]),
      .closed_eff  (chain[j+1]),
      .closed_nxt  (closed_nxt[j])
    );
  end

  kdp_upsum u_upsum (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .price     (price_m),
    .total_nxt (up_total_nxt)
  );

  // Pick the cell for k transactions, k limited to the number of cells.
  assign k_sat = ({2'b00, max_tx_r} > CELLS_K) ? CELLS_K : {2'b00, max_tx_r};
  assign sel   = SEL_W'(k_sat - 7'd1);

  always_comb begin
    priority if (unlim_r) begin
      profit = up_total_nxt;
    end else if (k_sat == 7'd0) begin
      profit = '0;
    end else begin
      profit = closed_nxt[sel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= profit;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

@@ src/kdp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kdp_checker
// Port-level checks of the k-transaction profit block, bound to its top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kdp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata
);

  // A stalled result word keeps its value.
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Every taken word produces a result word in the next cycle.
  `ASSERT_NEXT(a_result_follows, clk, rst_n, in_tvalid && in_tready, out_tvalid)

  // A result word never appears without a word having been taken.
  `ASSERT_IMPLY(a_no_phantom, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready))

  // With the result buffer empty, the input side is never stalled.
  `ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)

endmodule

bind k_transaction_max_profit_dp kdp_checker u_kdp_checker (.*);

@@ bench/tb_k_transaction_max_profit_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_k_transaction_max_profit_dp
// Self-checking testbench for the k-transaction best profit block.
// ----------------------------------------------------------------------------
// Price words are queued by the stimulus process and sent by a clocked driver
// that inserts random gaps. At every accepted word the driver runs a local
// model of the transaction cells and the upward-step sum, and it queues the
// profit that the block must report. A clocked monitor stalls the result side
// at random and compares each result word with the oldest queued profit. The
// run covers a short directed part, random phases under several register
// settings (the limits included), and a short swing between the price
// extremes at full rate.
// ----------------------------------------------------------------------------
module tb_k_transaction_max_profit_dp;

  localparam int MAX_CELLS   = 16;
  localparam int PRICE_BITS  = 16;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_TICKS = 20;
  localparam longint SAT32   = 64'h0000_0000_FFFF_FFFF;
  localparam longint NEG_INF = -(64'sd1 <<< 33);

  typedef struct packed {
    logic [15:0] price;
    logic        start;
  } price_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;     // [15:0] price
  logic        in_tuser = 1'b0;   // [0] series_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;         // [31:0] best_profit
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  k_transaction_max_profit_dp #(
    .MAX_CELLS (MAX_CELLS),
    .PRICE_BITS(PRICE_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #4 clk = ~clk;

  // Words waiting to be sent, and the profits the block still owes us.
  price_word_t price_queue[$];
  logic [31:0] profit_due[$];

  // Model copy of the registers and of the series state.
  logic [4:0] limit_k = kdp_pkg::MAX_TRANSACTIONS_RST;
  logic       sum_mode = 1'b0;
  longint     hold_best[MAX_CELLS];
  longint     closed_best[MAX_CELLS];
  longint     last_price;
  bit         seen_price;
  longint     rise_sum;

  int  fail_count = 0;
  bit  in_gaps_on = 1'b1;
  bit  out_stalls_on = 1'b1;
  int  send_gap = 0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  logic [31:0] want_profit;

  // Clears every cell and the upward sum, as a series start does.
  function automatic void series_clear();
    int j;
    for (j = 0; j < MAX_CELLS; j++) begin
      hold_best[j]   = NEG_INF;
      closed_best[j] = 0;
    end
    last_price = 0;
    seen_price = 1'b0;
    rise_sum   = 0;
  endfunction

  // Advances the model by one price word and returns the profit to report.
  // All cells update from their previous values: cell j sells out of its own
  // holding and buys with the old closed value of cell j-1.
  function automatic logic [31:0] profit_step(input logic [15:0] price, input logic start);
    longint p;
    longint left_closed;
    longint old_hold;
    longint old_closed;
    longint sold;
    longint bought;
    int     j;
    int     k;
    p = longint'(price) & ((64'd1 << PRICE_BITS) - 1);
    if (start) series_clear();
    left_closed = 0;
    for (j = 0; j < MAX_CELLS; j++) begin
      old_hold   = hold_best[j];
      old_closed = closed_best[j];
      sold   = old_hold + p;
      bought = left_closed - p;
      if (sold > SAT32) sold = SAT32;
      closed_best[j] = (sold > old_closed) ? sold : old_closed;
      hold_best[j]   = (bought > old_hold) ? bought : old_hold;
      left_closed    = old_closed;
    end
    // The first price of a series has no step before it.
    if (seen_price && p > last_price) begin
      rise_sum = rise_sum + (p - last_price);
      if (rise_sum > SAT32) rise_sum = SAT32;
    end
    last_price = p;
    seen_price = 1'b1;
    if (sum_mode) return rise_sum[31:0];
    k = (limit_k > MAX_CELLS) ? MAX_CELLS : int'(limit_k);
    if (k == 0) return '0;
    return closed_best[k-1][31:0];
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Input driver. The expected profit is worked out at the edge where the
  // word is taken, so it always sees the registers that the block sees.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) profit_due = {profit_due, profit_step(in_tdata, in_tuser)};
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (price_queue.size() > 0) begin
          in_tdata  <= price_queue[0].price;
          in_tuser  <= price_queue[0].start;
          in_tvalid <= 1'b1;
          void'(price_queue.pop_front());
          send_gap = pick_gap(in_gaps_on);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each word taken and picks the next stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (profit_due.size() == 0) begin
          $error("unexpected result word: best_profit %0d", out_tdata);
          fail_count++;
        end else begin
          want_profit = profit_due.pop_front();
          if (out_tdata !== want_profit) begin
            $error("best_profit mismatch: expected %0d, actual %0d", want_profit, out_tdata);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap(out_stalls_on);
      end
    end
  end

  // Watchdog: any handshake on any port counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("k_transaction_max_profit_dp regression: fail");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Writes one register, updates the model copy, and reads it back.
  task automatic write_reg(input logic reg_idx, input logic [31:0] value);
    logic [31:0] readback;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (reg_idx == kdp_pkg::REG_MAX_TRANSACTIONS) limit_k = value[4:0];
    else sum_mode = value[0];
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_idx == kdp_pkg::REG_MAX_TRANSACTIONS && readback !== {27'd0, limit_k}) begin
      $error("max_transactions readback: expected %0d, actual %0d", limit_k, readback);
      fail_count++;
    end
    if (reg_idx == kdp_pkg::REG_UNLIMITED_MODE && readback !== {31'd0, sum_mode}) begin
      $error("unlimited_mode readback: expected %0d, actual %0d", sum_mode, readback);
      fail_count++;
    end
  endtask

  task automatic add_word(input int price, input bit start);
    price_word_t w;
    w.price = price[15:0];
    w.start = start;
    price_queue = {price_queue, w};
  endtask

  // Blocks until every queued word is sent and every result has come back.
  // Each word yields a result, so nothing is still in flight after that.
  task automatic drain();
    while (price_queue.size() > 0 || in_tvalid || profit_due.size() > 0) @(posedge clk);
  endtask

  // One series: a start word and random prices in one of three styles. Some
  // series lose their start flag, and a few stray starts land mid-series.
  task automatic add_series();
    int len;
    int style;
    int p;
    int i;
    bit start;
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 24);
    style = $urandom_range(0, 2);
    p     = $urandom_range(0, 65535);
    for (i = 0; i < len; i++) begin
      case (style)
        0: p = $urandom_range(0, 65535);
        1: p = $urandom_range(0, 15);
        default: begin
          p = p + $urandom_range(0, 600) - 300;
          if (p < 0) p = 0;
          if (p > 65535) p = 65535;
        end
      endcase
      if (i == 0) start = ($urandom_range(0, 9) != 0);
      else start = ($urandom_range(0, 24) == 0);
      add_word(p, start);
    end
  endtask

  int phase;
  int n_words;
  int k_pick;

  initial begin
    series_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A word without a start flag right after reset runs on
    // the reset state; then extremes under the reset limit of two.
    write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, 32'd2);
    write_reg(kdp_pkg::REG_UNLIMITED_MODE, 32'd0);
    add_word(100, 1'b0);
    add_word(65535, 1'b0);
    add_word(0, 1'b1);
    add_word(65535, 1'b0);
    add_word(0, 1'b0);
    add_word(65535, 1'b0);
    drain();

    // Switch to the upward sum in the middle of the series: flat and falling
    // steps add nothing.
    write_reg(kdp_pkg::REG_UNLIMITED_MODE, 32'd1);
    add_word(65535, 1'b0);
    add_word(65535, 1'b0);
    add_word(3, 1'b0);
    drain();

    // A zero limit reports zero; the first word of the series adds no step.
    write_reg(kdp_pkg::REG_UNLIMITED_MODE, 32'd0);
    write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, 32'd0);
    add_word(1, 1'b1);
    add_word(9, 1'b0);
    drain();

    // A limit beyond the cell count acts as the cell count.
    write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, 32'd31);
    add_word(0, 1'b0);
    add_word(60000, 1'b0);
    add_word(5, 1'b0);
    drain();
    write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, 32'd16);
    add_word(40000, 1'b0);
    drain();

    write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, 32'd1);
    add_word(2, 1'b1);
    add_word(5, 1'b0);
    add_word(1, 1'b0);
    add_word(4, 1'b0);
    drain();

    // Random phases, each under its own setting. Every phase ends with the
    // sender held back until all results are in.
    for (phase = 0; phase < 14; phase++) begin
      in_gaps_on    = (phase % 4) != 1;
      out_stalls_on = (phase % 3) != 2;
      k_pick = $urandom_range(0, 7);
      case (k_pick)
        0: write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, 32'd0);
        1: write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, 32'd1);
        2: write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, 32'd16);
        3: write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, 32'd31);
        4: write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, 32'd17);
        default: write_reg(kdp_pkg::REG_MAX_TRANSACTIONS, $urandom_range(0, 31));
      endcase
      write_reg(kdp_pkg::REG_UNLIMITED_MODE, ($urandom_range(0, 3) == 0) ? 32'd1 : 32'd0);
      n_words = 0;
      while (n_words < 100) begin
        add_series();
        n_words = price_queue.size();
      end
      drain();
    end

    // Short swing between the price extremes with no gaps on either side,
    // so this part runs at full rate.
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    write_reg(kdp_pkg::REG_UNLIMITED_MODE, 32'd1);
    add_word(0, 1'b1);
    add_word(65535, 1'b0);
    for (n_words = 0; n_words < 8; n_words++) begin
      add_word(0, 1'b0);
      add_word(65535, 1'b0);
    end
    drain();

    repeat (DRAIN_TICKS) @(posedge clk);
    if (profit_due.size() != 0) begin
      $error("%0d expected result words never arrived", profit_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("k_transaction_max_profit_dp regression: pass");
    end else begin
      $display("k_transaction_max_profit_dp regression: fail");
    end
    $finish;
  end

endmodule
